FILE: design/spm_pkg.sv
// slotted page manager package: item types, slot entry layout, op and status codes
// used by the top level and by nothing else outside the generic ram
package spm_pkg;

  localparam int DEF_PAGE_BYTES   = 4096;
  localparam int DEF_HEADER_BYTES = 16;
  localparam int DEF_SLOT_BYTES   = 6;
  localparam int DEF_MAX_SLOTS    = 512;

  // pointer width holds the page size itself, calc width holds signed sums
  localparam int PTR_W  = 13;
  localparam int CALC_W = 15;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;
  localparam logic [2:0] OP_WRITE  = 3'd5;
  localparam logic [2:0] OP_READ   = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  slot;
    logic [11:0] tuple_length;
    logic [11:0] address;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  slot_out;
    logic [31:0] page_out;
    logic [11:0] tuple_offset;
    logic [11:0] length_out;
    logic [7:0]  read_data;
  } out_item_t;

  typedef struct packed {
    logic        dead;
    logic [11:0] len;
    logic [11:0] off;
  } slot_ent_t;

endpackage

FILE: design/spm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module spm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/slotted_page_manager_top.sv
// slotted page manager top level: page byte store, scratch store, slot directory
// depends on spm_pkg and spm_ram
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | spm_pkg::in_item_t
//  out     | output    | out_valid / out_ready | spm_pkg::out_item_t
//  cfg     | input     | cfg_valid / cfg_ready | 32-bit page number
//
// one item at a time; clear, write byte and op 7 go from idle straight to the response
// state; insert (unless full), delete, lookup, read byte and a shrinking update pass
// one more state first. a compaction walks the slot directory over the single slot
// ram port (read and write-back per dead slot; read, byte copy and rewrite per live
// slot) and then refills the page from min(lower, new top) to the page end at one
// byte a cycle; an update that grows may compact twice. no clearing pass after reset.
// a result waiting in the output register holds the next item in its last state;
// cfg is always ready.
module slotted_page_manager_top #(
  parameter int PAGE_BYTES   = spm_pkg::DEF_PAGE_BYTES,
  parameter int HEADER_BYTES = spm_pkg::DEF_HEADER_BYTES,
  parameter int SLOT_BYTES   = spm_pkg::DEF_SLOT_BYTES,
  parameter int MAX_SLOTS    = spm_pkg::DEF_MAX_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  spm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output spm_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  localparam int PAGE_AW = $clog2(PAGE_BYTES);
  localparam int SLOT_AW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
  localparam int PW      = spm_pkg::PTR_W;
  localparam int CW      = spm_pkg::CALC_W;
  localparam logic [PW-1:0] PAGE_END = PW'(PAGE_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SLOT  = 4'd1;
  localparam logic [3:0] S_INS   = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_UFIN  = 4'd4;
  localparam logic [3:0] S_BRD   = 4'd5;
  localparam logic [3:0] S_RESP  = 4'd6;
  localparam logic [3:0] S_CSRD  = 4'd7;
  localparam logic [3:0] S_CSWT  = 4'd8;
  localparam logic [3:0] S_CCPY  = 4'd9;
  localparam logic [3:0] S_CSWR  = 4'd10;
  localparam logic [3:0] S_CFIL  = 4'd11;
  localparam logic [3:0] S_CFEND = 4'd12;

  logic [3:0] state_r, state_nxt, ret_r, ret_nxt;
  spm_pkg::in_item_t  item_r, item_nxt;
  spm_pkg::out_item_t res_r, res_nxt, out_data_r, out_data_nxt;
  spm_pkg::slot_ent_t ent_r, ent_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] page_num_r, page_num_nxt;
  logic [9:0]  used_r, used_nxt, ci_r, ci_nxt;
  logic [PW-1:0] lower_r, lower_nxt, upper_r, upper_nxt, top_r, top_nxt;
  logic [PW-1:0] ck_r, ck_nxt, cp_dst_r, cp_dst_nxt, fk_d_r, fk_d_nxt;
  logic [11:0] cpy_off_r, cpy_off_nxt, cpy_len_r, cpy_len_nxt;
  logic        compacted_r, compacted_nxt;
  logic        copy_pend_r, copy_pend_nxt, cp_zero_r, cp_zero_nxt, cp_ok_r, cp_ok_nxt;
  logic        fill_pend_r, fill_pend_nxt;

  logic               page_we, scr_we, slot_we, byte_we;
  logic [PAGE_AW-1:0] page_waddr, page_raddr, scr_waddr, scr_raddr;
  logic [7:0]         page_wdata, page_rdata, scr_wdata, scr_rdata;
  logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
  spm_pkg::slot_ent_t slot_wdata, slot_rdata;
  logic [$bits(spm_pkg::slot_ent_t)-1:0] slot_rd_raw;

  logic accept, live;
  logic signed [CW-1:0] free_s, len_s, ins_need_s, upd_room_s, top_sub_s;
  logic [PW-1:0] new_up, src, dst;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_rdata = slot_rd_raw;

  assign free_s     = CW'(upper_r) - CW'(lower_r);
  assign len_s      = CW'(item_r.tuple_length);
  assign ins_need_s = len_s + CW'(SLOT_BYTES);
  assign upd_room_s = free_s + CW'(ent_r.len);
  assign top_sub_s  = CW'(top_r) - CW'(slot_rdata.len);
  assign new_up     = upper_r - PW'(item_r.tuple_length);
  assign src        = PW'(cpy_off_r) + ck_r;
  assign dst        = top_r + ck_r;
  assign live       = ({1'b0, item_r.slot} < used_r) && !slot_rdata.dead &&
                      (slot_rdata.len != 12'd0);
  assign byte_we    = accept && (in_data.op == spm_pkg::OP_WRITE) &&
                      ({1'b0, in_data.address} < PAGE_END);

  // delayed writes of the copy and fill pipelines
  always_comb begin
    scr_we    = copy_pend_r && cp_ok_r;
    scr_waddr = cp_dst_r[PAGE_AW-1:0];
    scr_wdata = cp_zero_r ? 8'd0 : page_rdata;
    scr_raddr = ck_r[PAGE_AW-1:0];
    if (fill_pend_r) begin
      page_we    = 1'b1;
      page_waddr = fk_d_r[PAGE_AW-1:0];
      page_wdata = (fk_d_r >= top_r) ? scr_rdata : 8'd0;
    end else begin
      page_we    = byte_we;
      page_waddr = in_data.address[PAGE_AW-1:0];
      page_wdata = in_data.data_byte;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    ent_nxt       = ent_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    page_num_nxt  = page_num_r;
    used_nxt      = used_r;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    top_nxt       = top_r;
    ci_nxt        = ci_r;
    ck_nxt        = ck_r;
    cpy_off_nxt   = cpy_off_r;
    cpy_len_nxt   = cpy_len_r;
    compacted_nxt = compacted_r;
    copy_pend_nxt = 1'b0;
    cp_dst_nxt    = cp_dst_r;
    cp_zero_nxt   = cp_zero_r;
    cp_ok_nxt     = cp_ok_r;
    fill_pend_nxt = 1'b0;
    fk_d_nxt      = fk_d_r;
    page_raddr    = in_data.address[PAGE_AW-1:0];
    slot_raddr    = in_data.slot[SLOT_AW-1:0];
    slot_we       = 1'b0;
    slot_waddr    = item_r.slot[SLOT_AW-1:0];
    slot_wdata    = ent_r;

    if (cfg_valid) begin
      page_num_nxt = cfg_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt      = in_data;
          res_nxt       = '0;
          compacted_nxt = 1'b0;
          state_nxt     = S_RESP;
          case (in_data.op)
            spm_pkg::OP_CLEAR: begin
              used_nxt  = '0;
              lower_nxt = PW'(HEADER_BYTES);
              upper_nxt = PAGE_END;
            end
            spm_pkg::OP_INSERT: begin
              if (used_r >= 10'(MAX_SLOTS)) begin
                res_nxt.status = spm_pkg::ST_FULL;
              end else begin
                state_nxt = S_INS;
              end
            end
            spm_pkg::OP_UPDATE, spm_pkg::OP_DELETE, spm_pkg::OP_LOOKUP: begin
              state_nxt = S_SLOT;
            end
            spm_pkg::OP_READ: begin
              state_nxt = S_BRD;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SLOT: begin
        ent_nxt          = slot_rdata;
        res_nxt.slot_out = item_r.slot;
        state_nxt        = S_RESP;
        if (!live) begin
          res_nxt.status = spm_pkg::ST_NOT_FOUND;
        end else begin
          case (item_r.op)
            spm_pkg::OP_DELETE: begin
              slot_we    = 1'b1;
              slot_wdata = '{dead: 1'b1, len: 12'd0, off: slot_rdata.off};
            end
            spm_pkg::OP_LOOKUP: begin
              res_nxt.tuple_offset = slot_rdata.off;
              res_nxt.length_out   = slot_rdata.len;
            end
            default: begin
              if (item_r.tuple_length <= slot_rdata.len) begin
                slot_we    = 1'b1;
                slot_wdata = '{dead: 1'b0, len: item_r.tuple_length, off: slot_rdata.off};
                res_nxt.tuple_offset = slot_rdata.off;
              end else begin
                state_nxt = S_UPD;
              end
            end
          endcase
        end
      end
      S_UPD: begin
        ci_nxt    = '0;
        top_nxt   = PAGE_END;
        state_nxt = S_CSRD;
        if (len_s > upd_room_s) begin
          ret_nxt = S_UPD;
          if (compacted_r) begin
            res_nxt.status = spm_pkg::ST_NO_SPACE;
            state_nxt      = S_RESP;
          end
        end else begin
          // drop the old tuple, then repack before taking new space
          slot_we    = 1'b1;
          slot_wdata = '{dead: 1'b1, len: 12'd0, off: ent_r.off};
          ret_nxt    = S_UFIN;
        end
      end
      S_UFIN: begin
        slot_we    = 1'b1;
        slot_wdata = '{dead: 1'b0, len: item_r.tuple_length, off: new_up[11:0]};
        upper_nxt  = new_up;
        res_nxt.tuple_offset = new_up[11:0];
        state_nxt  = S_RESP;
      end
      S_INS: begin
        if (free_s >= ins_need_s) begin
          slot_we    = 1'b1;
          slot_waddr = used_r[SLOT_AW-1:0];
          slot_wdata = '{dead: 1'b0, len: item_r.tuple_length, off: new_up[11:0]};
          upper_nxt  = new_up;
          lower_nxt  = lower_r + PW'(SLOT_BYTES);
          used_nxt   = used_r + 10'd1;
          res_nxt.slot_out     = used_r[8:0];
          res_nxt.page_out     = page_num_r;
          res_nxt.tuple_offset = new_up[11:0];
          state_nxt  = S_RESP;
        end else if (compacted_r) begin
          res_nxt.status = spm_pkg::ST_NO_SPACE;
          state_nxt      = S_RESP;
        end else begin
          ci_nxt    = '0;
          top_nxt   = PAGE_END;
          ret_nxt   = S_INS;
          state_nxt = S_CSRD;
        end
      end
      S_BRD: begin
        res_nxt.read_data = ({1'b0, item_r.address} < PAGE_END) ? page_rdata : 8'd0;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CSRD: begin
        if (ci_r >= used_r) begin
          ck_nxt    = (lower_r < top_r) ? lower_r : top_r;
          state_nxt = S_CFIL;
        end else begin
          slot_raddr = ci_r[SLOT_AW-1:0];
          state_nxt  = S_CSWT;
        end
      end
      S_CSWT: begin
        if (slot_rdata.dead) begin
          slot_we    = 1'b1;
          slot_waddr = ci_r[SLOT_AW-1:0];
          slot_wdata = '{dead: 1'b1, len: 12'd0, off: 12'd0};
          ci_nxt     = ci_r + 10'd1;
          state_nxt  = S_CSRD;
        end else begin
          // new top clamps at the page start
          top_nxt     = (top_sub_s < 0) ? '0 : top_sub_s[PW-1:0];
          cpy_off_nxt = slot_rdata.off;
          cpy_len_nxt = slot_rdata.len;
          ck_nxt      = '0;
          state_nxt   = S_CCPY;
        end
      end
      S_CCPY: begin
        if (ck_r < PW'(cpy_len_r)) begin
          page_raddr    = src[PAGE_AW-1:0];
          copy_pend_nxt = 1'b1;
          cp_dst_nxt    = dst;
          cp_zero_nxt   = (src >= PAGE_END);
          cp_ok_nxt     = (dst < PAGE_END);
          ck_nxt        = ck_r + PW'(1);
        end else begin
          state_nxt = S_CSWR;
        end
      end
      S_CSWR: begin
        slot_we    = 1'b1;
        slot_waddr = ci_r[SLOT_AW-1:0];
        slot_wdata = '{dead: 1'b0, len: cpy_len_r, off: top_r[11:0]};
        ci_nxt     = ci_r + 10'd1;
        state_nxt  = S_CSRD;
      end
      S_CFIL: begin
        if (ck_r < PAGE_END) begin
          fill_pend_nxt = 1'b1;
          fk_d_nxt      = ck_r;
          ck_nxt        = ck_r + PW'(1);
        end else begin
          state_nxt = S_CFEND;
        end
      end
      S_CFEND: begin
        upper_nxt     = top_r;
        compacted_nxt = 1'b1;
        state_nxt     = ret_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      page_num_r  <= '0;
      used_r      <= '0;
      lower_r     <= PW'(HEADER_BYTES);
      upper_r     <= PAGE_END;
      copy_pend_r <= 1'b0;
      fill_pend_r <= 1'b0;
      compacted_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      page_num_r  <= page_num_nxt;
      used_r      <= used_nxt;
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      copy_pend_r <= copy_pend_nxt;
      fill_pend_r <= fill_pend_nxt;
      compacted_r <= compacted_nxt;
    end
    ret_r      <= ret_nxt;
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    ent_r      <= ent_nxt;
    out_data_r <= out_data_nxt;
    top_r      <= top_nxt;
    ci_r       <= ci_nxt;
    ck_r       <= ck_nxt;
    cpy_off_r  <= cpy_off_nxt;
    cpy_len_r  <= cpy_len_nxt;
    cp_dst_r   <= cp_dst_nxt;
    cp_zero_r  <= cp_zero_nxt;
    cp_ok_r    <= cp_ok_nxt;
    fk_d_r     <= fk_d_nxt;
  end

  spm_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
    .clk(clk), .we(page_we), .waddr(page_waddr), .wdata(page_wdata),
    .raddr(page_raddr), .rdata(page_rdata)
  );

  spm_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_scratch (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );

  spm_ram #(.WIDTH($bits(spm_pkg::slot_ent_t)), .DEPTH(MAX_SLOTS)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rd_raw)
  );

  a_upper_in_page: assert property (@(posedge clk) disable iff (!rst_n)
    upper_r <= PAGE_END)
    else $error("upper pointer beyond page end");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= 10'(MAX_SLOTS))
    else $error("slot count beyond directory size");

  a_copy_from_copy: assert property (@(posedge clk) disable iff (!rst_n)
    copy_pend_r |-> $past(state_r) == S_CCPY)
    else $error("scratch write outside the copy walk");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(fill_pend_r && byte_we))
    else $error("page fill and byte write in the same cycle");

endmodule
